// ===== hdl/ethernet_rx_filter_demux_unit_assert.svh =====
// assertion macros for the receive filter
`ifndef ETHERNET_RX_FILTER_DEMUX_UNIT_ASSERT_SVH
`define ETHERNET_RX_FILTER_DEMUX_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ERFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("erfd assertion failed");

// next-cycle implication, checked outside reset
`define ERFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("erfd assertion failed");

`endif

// ===== hdl/erfd_pkg.sv =====
package erfd_pkg;

  localparam int unsigned MacW     = 48;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PosW     = 4;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [PosW-1:0] MacBytes  = 4'd6;
  localparam logic [PosW-1:0] TypeHiPos = 4'd12;
  localparam logic [PosW-1:0] TypeLoPos = 4'd13;
  localparam logic [PosW-1:0] HdrLen    = 4'd14;

  localparam logic [ByteW-1:0] BcastByte = 8'hFF;
  localparam logic [15:0]      TypeIpv4  = 16'h0800;
  localparam logic [15:0]      TypeArp   = 16'h0806;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgStationMac = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIpv4En     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgArpEn      = 2'd2;

  typedef enum logic [1:0] {
    ROUTE_IPV4 = 2'd0,
    ROUTE_ARP  = 2'd1,
    ROUTE_DROP = 2'd2
  } route_e;

  // byte of the station address at a given destination position
  function automatic logic [ByteW-1:0] mac_byte(input logic [MacW-1:0] mac,
                                                input logic [PosW-1:0] pos);
    logic [ByteW-1:0] b;
    unique case (pos)
      4'd0:    b = mac[47:40];
      4'd1:    b = mac[39:32];
      4'd2:    b = mac[31:24];
      4'd3:    b = mac[23:16];
      4'd4:    b = mac[15:8];
      default: b = mac[7:0];
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/erfd_if.sv =====
interface erfd_rx_if;
  logic                         valid;
  logic                         ready;
  logic [erfd_pkg::ByteW-1:0]   rx_byte;
  logic                         last_byte;
  modport source (output valid, rx_byte, last_byte, input ready);
  modport sink   (input valid, rx_byte, last_byte, output ready);
endinterface

interface erfd_res_if;
  logic                         valid;
  logic                         ready;
  logic [erfd_pkg::ByteW-1:0]   payload_byte;
  logic                         route;
  logic                         last_of_payload;
  logic                         empty_payload;
  modport source (output valid, payload_byte, route, last_of_payload, empty_payload,
                  input ready);
  modport sink   (input valid, payload_byte, route, last_of_payload, empty_payload,
                  output ready);
endinterface

interface erfd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [erfd_pkg::CfgIdxW-1:0]   index;
  logic [erfd_pkg::MacW-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/ethernet_rx_filter_demux_unit.sv =====
// channel  | dir | payload
// ---------+-----+------------------------------------------------
// rx_i     | in  | rx_byte[7:0], last_byte
// res_o    | out | payload_byte[7:0], route, last_of_payload, empty_payload
// cfg_i    | in  | index[1:0] (0 station_mac, 1 ipv4_enabled, 2 arp_enabled), data[47:0]
//
// one frame byte per cycle while intake is not stalled; any result it gives sits in the output register the next cycle
// the output register is refilled in the same cycle it is taken, so no bubbles
// a stalled output stops intake only while the held result is not taken
// rst_ni clears frame state, the configuration registers and the output valid; configuration writes always accepted
module ethernet_rx_filter_demux_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  erfd_rx_if.sink        rx_i,
  erfd_res_if.source     res_o,
  erfd_cfg_if.sink       cfg_i
);

  `include "ethernet_rx_filter_demux_unit_assert.svh"

  logic [erfd_pkg::MacW-1:0]  station_mac_q;
  logic                       ipv4_en_q;
  logic                       arp_en_q;

  logic [erfd_pkg::PosW-1:0]  pos_q, pos_d;
  logic                       addr_match_q, addr_match_d;
  logic                       addr_bcast_q, addr_bcast_d;
  logic [erfd_pkg::ByteW-1:0] type_hi_q, type_hi_d;
  erfd_pkg::route_e           route_q, route_d;

  logic                       res_valid_q;
  logic [erfd_pkg::ByteW-1:0] res_byte_q;
  logic                       res_route_q;
  logic                       res_last_q;
  logic                       res_empty_q;

  logic                       in_fire;
  logic                       out_free;
  logic                       has_res;
  logic [erfd_pkg::ByteW-1:0] res_byte_d;
  logic                       res_route_d;
  logic                       res_last_d;
  logic                       res_empty_d;
  logic [15:0]                ether_type;
  erfd_pkg::route_e           new_route;

  assign out_free = !res_valid_q || res_o.ready;
  assign rx_i.ready = out_free;
  assign in_fire = rx_i.valid && out_free;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_mac_q <= '0;
      ipv4_en_q     <= 1'b0;
      arp_en_q      <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        erfd_pkg::CfgStationMac: station_mac_q <= cfg_i.data;
        erfd_pkg::CfgIpv4En:     ipv4_en_q     <= cfg_i.data[0];
        erfd_pkg::CfgArpEn:      arp_en_q      <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign ether_type = {type_hi_q, rx_i.rx_byte};

  always_comb begin
    new_route = erfd_pkg::ROUTE_DROP;
    if (addr_match_q || addr_bcast_q) begin
      if (ether_type == erfd_pkg::TypeIpv4 && ipv4_en_q) begin
        new_route = erfd_pkg::ROUTE_IPV4;
      end else if (ether_type == erfd_pkg::TypeArp && arp_en_q) begin
        new_route = erfd_pkg::ROUTE_ARP;
      end
    end
  end

  always_comb begin
    pos_d        = pos_q;
    addr_match_d = addr_match_q;
    addr_bcast_d = addr_bcast_q;
    type_hi_d    = type_hi_q;
    route_d      = route_q;
    has_res      = 1'b0;
    res_byte_d   = rx_i.rx_byte;
    res_route_d  = route_q[0];
    res_last_d   = rx_i.last_byte;
    res_empty_d  = 1'b0;

    if (pos_q < erfd_pkg::MacBytes) begin
      if (rx_i.rx_byte != erfd_pkg::mac_byte(station_mac_q, pos_q)) begin
        addr_match_d = 1'b0;
      end
      if (rx_i.rx_byte != erfd_pkg::BcastByte) begin
        addr_bcast_d = 1'b0;
      end
    end else if (pos_q == erfd_pkg::TypeHiPos) begin
      type_hi_d = rx_i.rx_byte;
    end else if (pos_q == erfd_pkg::TypeLoPos) begin
      route_d = new_route;
      // header-only frame gives one empty result unless it is dropped
      if (rx_i.last_byte && new_route != erfd_pkg::ROUTE_DROP) begin
        has_res     = 1'b1;
        res_byte_d  = '0;
        res_route_d = new_route[0];
        res_empty_d = 1'b1;
      end
    end else if (pos_q >= erfd_pkg::HdrLen) begin
      has_res = (route_q != erfd_pkg::ROUTE_DROP);
    end

    if (pos_q < erfd_pkg::HdrLen) begin
      pos_d = pos_q + 4'd1;
    end

    if (rx_i.last_byte) begin
      pos_d        = '0;
      addr_match_d = 1'b1;
      addr_bcast_d = 1'b1;
      type_hi_d    = '0;
      route_d      = erfd_pkg::ROUTE_DROP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      addr_match_q <= 1'b1;
      addr_bcast_q <= 1'b1;
      type_hi_q    <= '0;
      route_q      <= erfd_pkg::ROUTE_DROP;
    end else if (in_fire) begin
      pos_q        <= pos_d;
      addr_match_q <= addr_match_d;
      addr_bcast_q <= addr_bcast_d;
      type_hi_q    <= type_hi_d;
      route_q      <= route_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= in_fire && has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      res_byte_q  <= res_byte_d;
      res_route_q <= res_route_d;
      res_last_q  <= res_last_d;
      res_empty_q <= res_empty_d;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.payload_byte    = res_byte_q;
  assign res_o.route           = res_route_q;
  assign res_o.last_of_payload = res_last_q;
  assign res_o.empty_payload   = res_empty_q;

  `ERFD_ASSERT_NEXT(a_restart_after_last, clk_i, rst_ni, in_fire && rx_i.last_byte,
                    pos_q == '0 && route_q == erfd_pkg::ROUTE_DROP)
  `ERFD_ASSERT_NOW(a_route_only_in_payload, clk_i, rst_ni,
                   route_q != erfd_pkg::ROUTE_DROP, pos_q == erfd_pkg::HdrLen)
  `ERFD_ASSERT_NOW(a_empty_is_last, clk_i, rst_ni, res_valid_q && res_empty_q,
                   res_last_q && res_byte_q == '0)
  `ERFD_ASSERT_NOW(a_stall_only_when_held, clk_i, rst_ni, !rx_i.ready,
                   res_valid_q && !res_o.ready)

endmodule
